>>> rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg - shared types and constants of the first-fit span allocator
// Field widths, status codes, sequencer states and owner table transfer types.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int SPACE_UNITS_DEF = 1024;
	localparam int TAG_COUNT_DEF   = 1024;

	localparam int CAP_W   = 11;
	localparam int LEN_W   = 11;
	localparam int POS_W   = 11;
	localparam int TAG_W   = 10;
	localparam int START_W = 10;
	localparam int TOTAL_W = 16;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_FIT  = 2'd1,
		STATUS_BAD_TAG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_SPLIT,
		ST_RELEASE
	} state_t;

	typedef struct packed {
		logic             en;
		logic             data_en;
		logic             valid;
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] len;
	} owner_wr_t;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] len;
	} owner_rd_t;

endpackage

>>> rtl/ffsa_owner_table.sv
// ----------------------------------------------------------------------------
// ffsa_owner_table - per-tag span records
// Valid flag store and start/length store, one write and one registered read
// per cycle. Only the valid store is swept clear by the owner.
// ----------------------------------------------------------------------------
module ffsa_owner_table #(
	parameter int  TAG_COUNT = ffsa_pkg::TAG_COUNT_DEF,
	localparam int TAG_AW    = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1
) (
	input  logic                clk,
	input  logic [TAG_AW-1:0]   rd_addr,
	input  logic [TAG_AW-1:0]   wr_addr,
	input  ffsa_pkg::owner_wr_t wr,
	output ffsa_pkg::owner_rd_t rd
);

	localparam int DATA_W = ffsa_pkg::POS_W + ffsa_pkg::LEN_W;

	logic              valid_mem [TAG_COUNT];
	logic [DATA_W-1:0] data_mem  [TAG_COUNT];
	ffsa_pkg::owner_rd_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			valid_mem[wr_addr] <= wr.valid;
			if (wr.data_en) begin
				data_mem[wr_addr] <= {wr.start, wr.len};
			end
		end
		rd_q.valid            <= valid_mem[rd_addr];
		{rd_q.start, rd_q.len} <= data_mem[rd_addr];
	end

	assign rd = rd_q;

endmodule

>>> rtl/first_fit_span_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_span_allocator - first-fit allocator over a linear unit space
// Segment chain in a memory, walked one header a cycle; per-tag records in
// an owner table. One item at a time under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                                  transfer
//  --------  ---------------------------------------  -----------------------
//  command   start, busy, func, tag, span_length      start & !busy
//  result    done, granted, status, start_unit,       done (one cycle, no
//            grant_total                              backpressure)
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid & cfg_ready
//
//  Allocate: the result follows the walk over the segment headers (one per
//  cycle through the segment memory read port), plus a write of any split
//  remainder in ST_SPLIT. Release: handled in ST_RELEASE. Bad tag or zero
//  length: answered from ST_IDLE. Reset and every capacity write start a
//  clearing pass over all segment headers and owner records, busy high.
//  busy drops in the cycle done is shown, so the next command can transfer.
// ----------------------------------------------------------------------------
module first_fit_span_allocator #(
	parameter int SPACE_UNITS = ffsa_pkg::SPACE_UNITS_DEF,
	parameter int TAG_COUNT   = ffsa_pkg::TAG_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [ffsa_pkg::TAG_W-1:0]   tag,
	input  logic [ffsa_pkg::LEN_W-1:0]   span_length,
	output logic                         done,
	output logic                         granted,
	output logic [1:0]                   status,
	output logic [ffsa_pkg::START_W-1:0] start_unit,
	output logic [ffsa_pkg::TOTAL_W-1:0] grant_total,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ffsa_pkg::CAP_W-1:0]   cfg_data
);

	localparam int CAP_W   = ffsa_pkg::CAP_W;
	localparam int LEN_W   = ffsa_pkg::LEN_W;
	localparam int POS_W   = ffsa_pkg::POS_W;
	localparam int START_W = ffsa_pkg::START_W;
	localparam int TOTAL_W = ffsa_pkg::TOTAL_W;
	localparam int SEG_W   = LEN_W + 1;
	localparam int SEG_AW  = (SPACE_UNITS > 1) ? $clog2(SPACE_UNITS) : 1;
	localparam int TAG_AW  = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
	localparam int CLR_N   = (SPACE_UNITS > TAG_COUNT) ? SPACE_UNITS : TAG_COUNT;
	localparam int CLR_AW  = $clog2(CLR_N);
	localparam logic [CAP_W-1:0] CAP_RESET =
		(SPACE_UNITS < 1024) ? CAP_W'(SPACE_UNITS) : CAP_W'(1024);

	ffsa_pkg::state_t  state_q, state_d;
	ffsa_pkg::status_t status_q, status_d;

	logic [CLR_AW-1:0]  clr_idx_q;
	logic [CAP_W-1:0]   cap_q;
	logic [CAP_W-1:0]   cap_new;
	logic [TAG_AW-1:0]  tag_idx_q;
	logic [LEN_W-1:0]   want_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   run_q;
	logic [POS_W-1:0]   run_start_q;
	logic [POS_W-1:0]   split_pos_q;
	logic [LEN_W-1:0]   split_len_q;
	logic [TOTAL_W-1:0] count_q;
	logic               done_q, done_d;
	logic               granted_q, granted_d;
	logic [START_W-1:0] start_q, start_d;

	logic               cmd_xfer, cfg_xfer, tag_ok;
	logic               clr_last, clr_in_seg, clr_in_tag;

	logic [SEG_W-1:0]   seg_mem [SPACE_UNITS];
	logic [SEG_W-1:0]   seg_rd_q;
	logic               seg_we;
	logic [SEG_AW-1:0]  seg_wa, seg_ra;
	logic [SEG_W-1:0]   seg_wd;

	logic               hdr_used;
	logic [LEN_W-1:0]   hdr_len;
	logic [POS_W:0]     hop_pos, run_sum, rem_pos;
	logic               fit, more, split_need;
	logic               grant_hit;

	ffsa_pkg::owner_wr_t own_wr;
	ffsa_pkg::owner_rd_t own_rd;
	logic [TAG_AW-1:0]   own_wa;

	assign cmd_xfer   = start && !busy;
	assign cfg_xfer   = cfg_valid && cfg_ready;
	assign tag_ok     = 32'(tag) < TAG_COUNT;
	assign clr_last   = 32'(clr_idx_q) == CLR_N - 1;
	assign clr_in_seg = 32'(clr_idx_q) < SPACE_UNITS;
	assign clr_in_tag = 32'(clr_idx_q) < TAG_COUNT;

	always_comb begin
		cap_new = (cfg_data == '0) ? CAP_W'(1) : cfg_data;
		if (32'(cap_new) > SPACE_UNITS) begin
			cap_new = CAP_W'(SPACE_UNITS);
		end
	end

	// header under the walk pointer
	assign hdr_used   = seg_rd_q[LEN_W];
	assign hdr_len    = seg_rd_q[LEN_W-1:0];
	assign hop_pos    = {1'b0, pos_q} + {1'b0, hdr_len};
	assign run_sum    = {1'b0, run_q} + {1'b0, hdr_len};
	assign rem_pos    = {1'b0, run_start_q} + {1'b0, want_q};
	assign fit        = !hdr_used && (run_sum >= {1'b0, want_q});
	assign split_need = run_sum != {1'b0, want_q};
	assign more       = hop_pos < {1'b0, cap_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffsa_pkg::ST_CLEAR: begin
				if (clr_last) state_d = ffsa_pkg::ST_IDLE;
			end
			ffsa_pkg::ST_IDLE: begin
				if (cmd_xfer && tag_ok) begin
					if (func == ffsa_pkg::FUNC_RELEASE) begin
						state_d = ffsa_pkg::ST_RELEASE;
					end else if (span_length != '0) begin
						state_d = ffsa_pkg::ST_WALK;
					end
				end
			end
			ffsa_pkg::ST_WALK: begin
				if (hdr_len == '0) begin
					state_d = ffsa_pkg::ST_IDLE;
				end else if (fit) begin
					state_d = split_need ? ffsa_pkg::ST_SPLIT : ffsa_pkg::ST_IDLE;
				end else if (!more) begin
					state_d = ffsa_pkg::ST_IDLE;
				end
			end
			ffsa_pkg::ST_SPLIT:   state_d = ffsa_pkg::ST_IDLE;
			ffsa_pkg::ST_RELEASE: state_d = ffsa_pkg::ST_IDLE;
			default:              state_d = ffsa_pkg::ST_CLEAR;
		endcase
		if (cfg_xfer) state_d = ffsa_pkg::ST_CLEAR;
	end

	// memory controls and result
	always_comb begin
		seg_we    = 1'b0;
		seg_wa    = '0;
		seg_wd    = '0;
		seg_ra    = '0;
		own_wr    = '0;
		own_wa    = '0;
		grant_hit = 1'b0;
		done_d    = 1'b0;
		granted_d = 1'b0;
		status_d  = ffsa_pkg::STATUS_NO_FIT;
		start_d   = '0;
		unique case (state_q)
			ffsa_pkg::ST_CLEAR: begin
				if (clr_in_seg) begin
					seg_we = 1'b1;
					seg_wa = SEG_AW'(clr_idx_q);
					seg_wd = (clr_idx_q == '0) ? {1'b0, cap_q} : '0;
				end
				if (clr_in_tag) begin
					own_wr.en = 1'b1;
					own_wa    = TAG_AW'(clr_idx_q);
				end
			end
			ffsa_pkg::ST_IDLE: begin
				if (cmd_xfer && !tag_ok) begin
					done_d   = 1'b1;
					status_d = ffsa_pkg::STATUS_BAD_TAG;
				end else if (cmd_xfer && func == ffsa_pkg::FUNC_ALLOC
						&& span_length == '0) begin
					done_d = 1'b1;
				end
			end
			ffsa_pkg::ST_WALK: begin
				seg_ra = SEG_AW'(hop_pos[POS_W-1:0]);
				if (hdr_len == '0) begin
					done_d = 1'b1;
				end else if (fit) begin
					seg_we         = 1'b1;
					seg_wa         = SEG_AW'(run_start_q);
					seg_wd         = {1'b1, want_q};
					own_wr.en      = 1'b1;
					own_wr.data_en = 1'b1;
					own_wr.valid   = 1'b1;
					own_wr.start   = run_start_q;
					own_wr.len     = want_q;
					own_wa         = tag_idx_q;
					grant_hit      = 1'b1;
					if (!split_need) begin
						done_d    = 1'b1;
						granted_d = 1'b1;
						status_d  = ffsa_pkg::STATUS_OK;
						start_d   = run_start_q[START_W-1:0];
					end
				end else if (!more) begin
					done_d = 1'b1;
				end
			end
			ffsa_pkg::ST_SPLIT: begin
				seg_we    = 1'b1;
				seg_wa    = SEG_AW'(split_pos_q);
				seg_wd    = {1'b0, split_len_q};
				done_d    = 1'b1;
				granted_d = 1'b1;
				status_d  = ffsa_pkg::STATUS_OK;
				start_d   = run_start_q[START_W-1:0];
			end
			ffsa_pkg::ST_RELEASE: begin
				done_d = 1'b1;
				if (own_rd.valid) begin
					seg_we    = 1'b1;
					seg_wa    = SEG_AW'(own_rd.start);
					seg_wd    = {1'b0, own_rd.len};
					own_wr.en = 1'b1;
					own_wa    = tag_idx_q;
					granted_d = 1'b1;
					status_d  = ffsa_pkg::STATUS_OK;
					start_d   = own_rd.start[START_W-1:0];
				end else begin
					status_d = ffsa_pkg::STATUS_BAD_TAG;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffsa_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			cap_q     <= CAP_RESET;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_xfer) begin
				cap_q     <= cap_new;
				count_q   <= '0;
				clr_idx_q <= '0;
			end else begin
				if (state_q == ffsa_pkg::ST_CLEAR) clr_idx_q <= clr_idx_q + CLR_AW'(1);
				// saturate the success count
				if (grant_hit && count_q != '1) count_q <= count_q + TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			tag_idx_q   <= TAG_AW'(tag);
			want_q      <= span_length;
			pos_q       <= '0;
			run_q       <= '0;
			run_start_q <= '0;
		end else if (state_q == ffsa_pkg::ST_WALK) begin
			pos_q <= hop_pos[POS_W-1:0];
			if (hdr_used) begin
				// used segment: restart the run after it
				run_q       <= '0;
				run_start_q <= hop_pos[POS_W-1:0];
			end else begin
				run_q <= run_sum[POS_W-1:0];
			end
			split_pos_q <= rem_pos[POS_W-1:0];
			split_len_q <= LEN_W'(run_sum - {1'b0, want_q});
		end
		if (done_d) begin
			granted_q <= granted_d;
			status_q  <= status_d;
			start_q   <= start_d;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_we) seg_mem[seg_wa] <= seg_wd;
		seg_rd_q <= seg_mem[seg_ra];
	end

	ffsa_owner_table #(
		.TAG_COUNT(TAG_COUNT)
	) u_owner (
		.clk     (clk),
		.rd_addr (TAG_AW'(tag)),
		.wr_addr (own_wa),
		.wr      (own_wr),
		.rd      (own_rd)
	);

	assign busy        = state_q != ffsa_pkg::ST_IDLE;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign granted     = granted_q;
	assign status      = status_q;
	assign start_unit  = start_q;
	assign grant_total = count_q;

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (granted_q == (status_q == ffsa_pkg::STATUS_OK)))
		else $error("granted and status disagree");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_xfer) |-> (count_q >= $past(count_q)))
		else $error("grant count went down without a capacity write");

	a_walk_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffsa_pkg::ST_WALK) |-> (pos_q < cap_q))
		else $error("walk pointer left the managed space");

endmodule
